// File: rtl/core/mur3_pkg.sv
// Shared types and constants of the MurmurHash3 x86_32 stream hasher.
// Used by mur3_front, mur3_queue, mur3_back and murmur3_32_stream_hash.
package mur3_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MIX_C2 = 32'h1b873593;
  localparam logic [WORD_W-1:0] FOLD_ADD = 32'he6546b64;
  localparam logic [WORD_W-1:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_C2 = 32'hc2b2ae35;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] mixed;
    logic [COUNT_W-1:0] count;
    logic last;
  } mur3_item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } mur3_state_t;

  function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
    rotl15 = {x[WORD_W-16:0], x[WORD_W-1:WORD_W-15]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    rotl13 = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
  endfunction

endpackage

// File: rtl/core/mur3_front.sv
// Front end: accepts key words, saturates and masks the tail, runs the word mix.
// Two registered multiply stages; depends on mur3_pkg.
module mur3_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [mur3_pkg::WORD_W-1:0]    data_word,
  input  logic [mur3_pkg::COUNT_W-1:0]   byte_count,
  input  logic                           last_item,
  output logic                           q_push,
  input  logic                           q_full,
  output mur3_pkg::mur3_item_t           q_item
);

  logic                          advance;
  logic [mur3_pkg::COUNT_W-1:0]  count_sat;
  logic [mur3_pkg::WORD_W-1:0]   masked;
  logic                          s1_valid;
  logic [mur3_pkg::WORD_W-1:0]   s1_k;
  logic [mur3_pkg::COUNT_W-1:0]  s1_count;
  logic                          s1_last;
  logic                          s2_valid;
  logic [mur3_pkg::WORD_W-1:0]   s2_k;
  logic [mur3_pkg::COUNT_W-1:0]  s2_count;
  logic                          s2_last;

  assign advance = !s2_valid || !q_full;
  assign full = !advance;

  always_comb begin
    if (!last_item || byte_count > mur3_pkg::COUNT_FULL) begin
      count_sat = mur3_pkg::COUNT_FULL;
    end else begin
      count_sat = byte_count;
    end
  end

  always_comb begin
    unique case (count_sat)
      mur3_pkg::COUNT_NONE:  masked = '0;
      mur3_pkg::COUNT_ONE:   masked = {24'd0, data_word[7:0]};
      mur3_pkg::COUNT_TWO:   masked = {16'd0, data_word[15:0]};
      mur3_pkg::COUNT_THREE: masked = {8'd0, data_word[23:0]};
      default:               masked = data_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_k <= masked * mur3_pkg::MIX_C1;
      s1_count <= count_sat;
      s1_last <= last_item;
      s2_k <= mur3_pkg::rotl15(s1_k) * mur3_pkg::MIX_C2;
      s2_count <= s1_count;
      s2_last <= s1_last;
    end
  end

  assign q_push = s2_valid && !q_full;
  assign q_item.mixed = s2_k;
  assign q_item.count = s2_count;
  assign q_item.last = s2_last;

endmodule

// File: rtl/core/mur3_queue.sv
// Short queue of mixed items between front and back ends.
// Depth from mur3_pkg::QUEUE_DEPTH; depends on mur3_pkg.
module mur3_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  mur3_pkg::mur3_item_t  wr_item,
  output logic                  q_full,
  input  logic                  rd_en,
  output logic                  q_empty,
  output mur3_pkg::mur3_item_t  rd_item
);

  mur3_pkg::mur3_item_t               slots [mur3_pkg::QUEUE_DEPTH];
  logic [mur3_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [mur3_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [mur3_pkg::QUEUE_CW-1:0]      fill;
  logic                               do_wr;
  logic                               do_rd;

  assign q_full = (fill == mur3_pkg::QUEUE_CW'(mur3_pkg::QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && !q_empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == mur3_pkg::QUEUE_AW'(mur3_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == mur3_pkg::QUEUE_AW'(mur3_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/mur3_back.sv
// Back end: folds mixed words into the running hash, finalizes, holds the result.
// Also holds the seed register; depends on mur3_pkg.
module mur3_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  mur3_pkg::mur3_item_t         q_item,
  output logic                         q_pop,
  input  logic                         cfg_valid,
  input  logic [mur3_pkg::WORD_W-1:0]  cfg_data,
  output logic                         empty,
  input  logic                         pop,
  output logic [mur3_pkg::WORD_W-1:0]  hash_value
);

  mur3_pkg::mur3_state_t          state;
  mur3_pkg::mur3_state_t          state_next;
  logic [mur3_pkg::WORD_W-1:0]    hash_seed;
  logic [mur3_pkg::WORD_W-1:0]    running_hash;
  logic [mur3_pkg::WORD_W-1:0]    key_length;
  logic                           key_started;
  logic [mur3_pkg::WORD_W-1:0]    acc;
  logic [mur3_pkg::WORD_W-1:0]    mixed_in;
  logic [mur3_pkg::WORD_W-1:0]    folded;
  logic [mur3_pkg::WORD_W-1:0]    tail_hash;
  logic [mur3_pkg::WORD_W-1:0]    length_next;
  logic                           out_valid;
  logic                           out_free;
  logic                           out_load;
  logic [mur3_pkg::WORD_W-1:0]    fin1_in;
  logic [mur3_pkg::WORD_W-1:0]    fin2_in;

  assign out_free = !out_valid || pop;

  always_comb begin
    mixed_in = running_hash ^ q_item.mixed;
    folded = (mur3_pkg::rotl13(mixed_in) << 2) + mur3_pkg::rotl13(mixed_in) + mur3_pkg::FOLD_ADD;
    if (q_item.count == mur3_pkg::COUNT_FULL) begin
      tail_hash = folded;
    end else if (q_item.count == mur3_pkg::COUNT_NONE) begin
      tail_hash = running_hash;
    end else begin
      tail_hash = mixed_in;
    end
    length_next = key_length + {{(mur3_pkg::WORD_W - mur3_pkg::COUNT_W){1'b0}}, q_item.count};
    fin1_in = acc ^ (acc >> 16);
    fin2_in = acc ^ (acc >> 13);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mur3_pkg::ST_RUN: begin
        if (!q_empty && q_item.last) begin
          state_next = mur3_pkg::ST_FIN1;
        end
      end
      mur3_pkg::ST_FIN1: state_next = mur3_pkg::ST_FIN2;
      mur3_pkg::ST_FIN2: state_next = mur3_pkg::ST_FIN3;
      mur3_pkg::ST_FIN3: begin
        if (out_free) begin
          state_next = mur3_pkg::ST_RUN;
        end
      end
      default: state_next = mur3_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    out_load = 1'b0;
    unique case (state)
      mur3_pkg::ST_RUN:  q_pop = !q_empty;
      mur3_pkg::ST_FIN3: out_load = out_free;
      default: begin
        q_pop = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mur3_pkg::ST_RUN;
      hash_seed <= '0;
      running_hash <= '0;
      key_length <= '0;
      key_started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        hash_seed <= cfg_data;
        if (!key_started) begin
          running_hash <= cfg_data;
        end
      end
      if (q_pop) begin
        if (q_item.last) begin
          running_hash <= hash_seed;
          key_length <= '0;
          key_started <= 1'b0;
        end else begin
          running_hash <= folded;
          key_length <= length_next;
          key_started <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mur3_pkg::ST_RUN:  acc <= tail_hash ^ length_next;
      mur3_pkg::ST_FIN1: acc <= fin1_in * mur3_pkg::FIN_C1;
      mur3_pkg::ST_FIN2: acc <= fin2_in * mur3_pkg::FIN_C2;
      default:           acc <= acc;
    endcase
    if (out_load) begin
      hash_value <= acc ^ (acc >> 16);
    end
  end

  assign empty = !out_valid;

endmodule

// File: rtl/core/murmur3_32_stream_hash.sv
// Top level of the MurmurHash3 x86_32 stream hasher.
// Instantiates mur3_front, mur3_queue and mur3_back; depends on mur3_pkg.
//
// Computes the 32-bit MurmurHash3 (x86_32) of a key streamed as little-endian
// 32-bit words. Push one word per cycle; mark the final word with last_item and
// give its valid byte count (0 to 4, larger values act as 4). Words before the
// last always count as four bytes. A non-last word passes through a two-stage
// multiply pipeline in the front end and folds into the running hash in the
// back end, so keys stream at one word per clock while full stays low. A last
// word is folded (ST_RUN), runs two registered finalizer multiplies (ST_FIN1,
// ST_FIN2) and waits in ST_FIN3 for a free output register; the queue is not
// read again until ST_RUN. The hash shows on hash_value while empty is low; it
// sits in an output register, so the front end keeps taking words while a
// result waits. Write the seed only while the block is idle; between keys it
// takes effect for the next key at once.
module murmur3_32_stream_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [mur3_pkg::WORD_W-1:0]  data_word,
  input  logic [mur3_pkg::COUNT_W-1:0] byte_count,
  input  logic                         last_item,
  output logic                         empty,
  input  logic                         pop,
  output logic [mur3_pkg::WORD_W-1:0]  hash_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mur3_pkg::WORD_W-1:0]  cfg_data
);

  logic                  fq_push;
  logic                  fq_full;
  mur3_pkg::mur3_item_t  fq_item;
  logic                  bq_pop;
  logic                  bq_empty;
  mur3_pkg::mur3_item_t  bq_item;

  assign cfg_ready = 1'b1;

  mur3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_item  (last_item),
    .q_push     (fq_push),
    .q_full     (fq_full),
    .q_item     (fq_item)
  );

  mur3_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_item (fq_item),
    .q_full  (fq_full),
    .rd_en   (bq_pop),
    .q_empty (bq_empty),
    .rd_item (bq_item)
  );

  mur3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (bq_empty),
    .q_item     (bq_item),
    .q_pop      (bq_pop),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

endmodule
